@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the retry backoff RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held
`define RBJ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property, checked through reset as well
`define RBJ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ rtl/rbj_pkg.sv @@
// ---------------------------------------------------------------------------
// rbj_pkg
// Shared widths, register indexes, codes and unit status types for the
// retry backoff with jitter block.
// ---------------------------------------------------------------------------
`default_nettype none

package rbj_pkg;

    // field widths
    localparam int BASE_W     = 31;
    localparam int ATT_W      = 8;
    localparam int RND_W      = 32;
    localparam int DLY_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // default width of the attempt counter
    localparam int COUNT_BITS_DEF = 8;

    // register reset values
    localparam logic [BASE_W-1:0] INIT_BASE_RST = 31'd100;
    localparam logic [BASE_W-1:0] MAX_BASE_RST  = 31'd1000;
    localparam logic [ATT_W-1:0]  MAX_ATT_RST   = 8'd4;

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_NOTE  = 1'b1;

    // status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_BASE = 2'd0,
        CFG_MAX_BASE     = 2'd1,
        CFG_MAX_ATTEMPTS = 2'd2
    } t_cfg_idx;

    // base sequencer result
    typedef struct packed {
        logic              done;
        logic [BASE_W-1:0] base;
    } t_base_res;

    // serial modulo result
    typedef struct packed {
        logic              done;
        logic [BASE_W-1:0] rem;
    } t_mod_res;

endpackage

`default_nettype wire

@@ rtl/rbj_ifs.sv @@
// ---------------------------------------------------------------------------
// rbj channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface rbj_in_if;
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic                     route_mode;
    logic                     attempt_failed;
    logic [rbj_pkg::RND_W-1:0] jitter_rnd;

    modport source (output valid, operation, route_mode, attempt_failed, jitter_rnd,
                    input ready);
    modport sink   (input valid, operation, route_mode, attempt_failed, jitter_rnd,
                    output ready);
endinterface

interface rbj_out_if;
    logic                     valid;
    logic                     ready;
    logic                     status;
    logic                     counted;
    logic                     exhausted;
    logic                     retry_now;
    logic [rbj_pkg::DLY_W-1:0] backoff_ms;

    modport source (output valid, status, counted, exhausted, retry_now, backoff_ms,
                    input ready);
    modport sink   (input valid, status, counted, exhausted, retry_now, backoff_ms,
                    output ready);
endinterface

interface rbj_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rbj_pkg::CFG_IDX_W-1:0]  index;
    logic [rbj_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/rbj_base.sv @@
// ---------------------------------------------------------------------------
// rbj_base
// Backoff base sequencer: doubles the initial base one round per cycle,
// jumps to the maximum once the base reaches half of it, clamps at the end.
// ---------------------------------------------------------------------------
`default_nettype none

module rbj_base #(
    parameter int COUNT_BITS = rbj_pkg::COUNT_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire  [COUNT_BITS-1:0]         i_rounds,
    input  wire  [rbj_pkg::BASE_W-1:0]    i_init,
    input  wire  [rbj_pkg::BASE_W-1:0]    i_max,
    output rbj_pkg::t_base_res            o_res
);

    logic                        r_busy,  n_busy;
    logic                        r_done,  n_done;
    logic [COUNT_BITS-1:0]       r_rounds, n_rounds;
    logic [rbj_pkg::BASE_W-1:0]  r_base,  n_base;
    logic [rbj_pkg::BASE_W-1:0]  r_res,   n_res;
    logic [rbj_pkg::BASE_W-1:0]  half;

    assign half = i_max >> 1;

    // one doubling round per cycle; a zero base stays zero, so stop early
    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_rounds = r_rounds;
        n_base   = r_base;
        n_res    = r_res;
        if (i_start) begin
            n_busy   = 1'b1;
            n_rounds = i_rounds;
            n_base   = i_init;
        end else if (r_busy) begin
            if (r_rounds != '0 && r_base >= half) begin
                n_res  = i_max;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else if (r_rounds == '0 || r_base == '0) begin
                n_res  = (r_base > i_max) ? i_max : r_base;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                // base is below half the maximum here, so no bit is lost
                n_base   = {r_base[rbj_pkg::BASE_W-2:0], 1'b0};
                n_rounds = r_rounds - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rounds <= n_rounds;
        r_base   <= n_base;
        r_res    <= n_res;
    end

    assign o_res.done = r_done;
    assign o_res.base = r_res;

endmodule

`default_nettype wire

@@ rtl/rbj_mod.sv @@
// ---------------------------------------------------------------------------
// rbj_mod
// Bit-serial restoring modulo: random word mod (base + 1), one dividend
// bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rbj_mod (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [rbj_pkg::BASE_W-1:0]   i_base,
    input  wire  [rbj_pkg::RND_W-1:0]    i_dividend,
    output rbj_pkg::t_mod_res            o_res
);

    localparam int RW    = rbj_pkg::RND_W;
    localparam int CNT_W = $clog2(RW);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [RW-1:0]     r_dvd,  n_dvd;
    logic [RW-1:0]     r_div,  n_div;
    logic [RW-1:0]     r_rem,  n_rem;
    logic [RW-1:0]     shifted;
    logic [RW:0]       trial;

    // next partial remainder with the dividend's top bit brought in
    assign shifted = {r_rem[RW-2:0], r_dvd[RW-1]};
    assign trial   = {1'b0, shifted} - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(RW - 1);
            n_dvd  = i_dividend;
            n_div  = RW'(i_base) + RW'(1);
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = trial[RW] ? shifted : trial[RW-1:0];
            n_dvd = {r_dvd[RW-2:0], 1'b0};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    // remainder stays below base + 1, so it fits the base width
    assign o_res.done = r_done;
    assign o_res.rem  = r_rem[rbj_pkg::BASE_W-1:0];

endmodule

`default_nettype wire

@@ rtl/retry_backoff_with_jitter_top.sv @@
// ---------------------------------------------------------------------------
// retry_backoff_with_jitter_top
// Truncated exponential backoff with jitter: tracks the retry sequence,
// counts attempts and computes the retry delay with serial units.
// ---------------------------------------------------------------------------
//  port    | dir | beat contents
//  i_in    | in  | operation, route_mode, attempt_failed, jitter_rnd
//  o_out   | out | status, counted, exhausted, retry_now, backoff_ms
//  i_cfg   | in  | index, data (register write, always ready)
//
//  One item at a time; i_in.ready is high only while the controller is idle.
//  Starts, errors, successes and exhausted failures go from idle straight to S_DONE.
//  Retries: the base sequencer (at most 30 doublings, one per cycle) runs in S_BASE,
//  then the bit-serial modulo over the 32 dividend bits in S_MOD, then S_DONE.
//  The result sits in an output register, so a stalled o_out does not block
//  the next input beat; a second result waits until that register empties.
//  Synchronous active-low reset clears control state and loads register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module retry_backoff_with_jitter_top #(
    parameter int COUNT_BITS = rbj_pkg::COUNT_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rbj_in_if.sink      i_in,
    rbj_out_if.source   o_out,
    rbj_cfg_if.sink     i_cfg
);

    localparam int BW    = rbj_pkg::BASE_W;
    localparam int DW    = rbj_pkg::DLY_W;
    localparam int AW    = rbj_pkg::ATT_W;
    localparam int CMP_W = (COUNT_BITS > AW) ? COUNT_BITS : AW;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_BASE = 4'b0010,
        S_MOD  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // configuration registers
    logic [BW-1:0] r_init, r_max;
    logic [AW-1:0] r_att;

    // sequence state
    t_state                r_state, n_state;
    logic                  r_started, n_started;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [BW-1:0]         r_cur_base, n_cur_base;
    logic [rbj_pkg::RND_W-1:0] r_rnd, n_rnd;

    // pending result
    logic          r_res_status, n_res_status;
    logic          r_res_cons,   n_res_cons;
    logic          r_res_exh,    n_res_exh;
    logic          r_res_retry,  n_res_retry;
    logic [DW-1:0] r_res_delay,  n_res_delay;

    // output register
    logic          r_ov, n_ov;
    logic          r_o_status, r_o_cons, r_o_exh, r_o_retry;
    logic [DW-1:0] r_o_delay;
    logic          load_out;

    logic                  in_acc, out_acc;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  at_limit;
    logic                  base_start;
    logic [COUNT_BITS-1:0] base_rounds;
    rbj_pkg::t_base_res    base_res;
    rbj_pkg::t_mod_res     mod_res;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid & i_in.ready;
    assign out_acc     = r_ov & o_out.ready;
    assign i_cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= rbj_pkg::INIT_BASE_RST;
            r_max  <= rbj_pkg::MAX_BASE_RST;
            r_att  <= rbj_pkg::MAX_ATT_RST;
        end else if (i_cfg.valid) begin
            case (rbj_pkg::t_cfg_idx'(i_cfg.index))
                rbj_pkg::CFG_INITIAL_BASE: r_init <= i_cfg.data;
                rbj_pkg::CFG_MAX_BASE:     r_max  <= i_cfg.data;
                rbj_pkg::CFG_MAX_ATTEMPTS: r_att  <= i_cfg.data[AW-1:0];
                default: ;
            endcase
        end
    end

    // saturating attempt count and limit check
    assign cnt_inc     = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign at_limit    = CMP_W'(cnt_inc) >= CMP_W'(r_att);
    assign base_rounds = cnt_inc - 1'b1;
    assign base_start  = in_acc && (i_in.operation == rbj_pkg::OP_NOTE) && r_started
                         && i_in.attempt_failed && !at_limit;

    rbj_base #(
        .COUNT_BITS (COUNT_BITS)
    ) u_base (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (base_start),
        .i_rounds (base_rounds),
        .i_init   (r_init),
        .i_max    (r_max),
        .o_res    (base_res)
    );

    rbj_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (base_res.done),
        .i_base     (base_res.base),
        .i_dividend (r_rnd),
        .o_res      (mod_res)
    );

    assign load_out = (r_state == S_DONE) && (!r_ov || o_out.ready);

    // controller
    always_comb begin
        n_state      = r_state;
        n_started    = r_started;
        n_cnt        = r_cnt;
        n_cur_base   = r_cur_base;
        n_rnd        = r_rnd;
        n_res_status = r_res_status;
        n_res_cons   = r_res_cons;
        n_res_exh    = r_res_exh;
        n_res_retry  = r_res_retry;
        n_res_delay  = r_res_delay;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_status = rbj_pkg::ST_OK;
                    n_res_cons   = 1'b0;
                    n_res_exh    = 1'b0;
                    n_res_retry  = 1'b0;
                    n_res_delay  = '0;
                    n_rnd        = i_in.jitter_rnd;
                    n_state      = S_DONE;
                    if (i_in.operation == rbj_pkg::OP_START) begin
                        if (!i_in.route_mode) begin
                            n_res_status = rbj_pkg::ST_ERR;
                        end else begin
                            n_started  = 1'b1;
                            n_cnt      = '0;
                            n_cur_base = '0;
                        end
                    end else if (!r_started) begin
                        n_res_status = rbj_pkg::ST_ERR;
                    end else begin
                        n_cnt      = cnt_inc;
                        n_res_cons = 1'b1;
                        if (i_in.attempt_failed) begin
                            if (at_limit) begin
                                n_res_exh = 1'b1;
                            end else begin
                                n_state = S_BASE;
                            end
                        end
                    end
                end
            end
            S_BASE: begin
                if (base_res.done) begin
                    n_cur_base = base_res.base;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_res.done) begin
                    n_res_retry = 1'b1;
                    n_res_delay = DW'(r_cur_base) + DW'(mod_res.rem);
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb begin
        n_ov = r_ov & ~out_acc;
        if (load_out) begin
            n_ov = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_started  <= 1'b0;
            r_cnt      <= '0;
            r_cur_base <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_started  <= n_started;
            r_cnt      <= n_cnt;
            r_cur_base <= n_cur_base;
            r_ov       <= n_ov;
        end
        r_rnd        <= n_rnd;
        r_res_status <= n_res_status;
        r_res_cons   <= n_res_cons;
        r_res_exh    <= n_res_exh;
        r_res_retry  <= n_res_retry;
        r_res_delay  <= n_res_delay;
        if (load_out) begin
            r_o_status <= r_res_status;
            r_o_cons   <= r_res_cons;
            r_o_exh    <= r_res_exh;
            r_o_retry  <= r_res_retry;
            r_o_delay  <= r_res_delay;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.status     = r_o_status;
    assign o_out.counted    = r_o_cons;
    assign o_out.exhausted  = r_o_exh;
    assign o_out.retry_now  = r_o_retry;
    assign o_out.backoff_ms = r_o_delay;

    // assertions
    `RBJ_ASSERT(a_cnt_no_drop, i_clk, i_rst_n,
        !(in_acc && i_in.operation == rbj_pkg::OP_START) |=> r_cnt >= $past(r_cnt),
        "attempt count dropped without a start")
    `RBJ_ASSERT(a_base_le_max, i_clk, i_rst_n,
        base_res.done |-> base_res.base <= r_max,
        "backoff base above maximum")
    `RBJ_ASSERT_ALWAYS(a_rem_le_base, i_clk,
        mod_res.done |-> mod_res.rem <= r_cur_base,
        "jitter remainder above base")

endmodule

`default_nettype wire

@@ test/rbj_backoff_checker.sv @@
// ---------------------------------------------------------------------------
// rbj_backoff_checker
// Watches the input, result and register channels of the retry backoff
// block, predicts each retry decision from its own copy of the sequence
// state and settings, and compares every result beat with the oldest
// predicted decision.
// ---------------------------------------------------------------------------
module rbj_backoff_checker #(
    parameter int COUNT_BITS = rbj_pkg::COUNT_BITS_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    rbj_in_if    i_in,
    rbj_out_if   i_out,
    rbj_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rbj_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic             status;
        logic             counted;
        logic             exhausted;
        logic             retry_now;
        logic [DLY_W-1:0] backoff_ms;
    } t_decision;

    // shadow settings
    logic [BASE_W-1:0]     init_base;
    logic [BASE_W-1:0]     max_base;
    logic [ATT_W-1:0]      attempt_limit;

    // shadow sequence state
    logic                  seq_open;
    logic [COUNT_BITS-1:0] attempt_count;
    logic [BASE_W-1:0]     last_base;

    t_decision             decisions_due[$];
    int                    mismatches = 0;

    // base for a retry: doubled once per earlier attempt, snaps to the
    // maximum once it reaches half of it, never above the maximum
    function automatic logic [BASE_W-1:0] retry_base(int rounds);
        logic [BASE_W-1:0] base;
        logic [BASE_W-1:0] half;
        base = init_base;
        half = max_base >> 1;
        for (int r = 0; r < rounds; r++) begin
            if (base >= half)
                return max_base;
            base = base << 1;
        end
        return (base > max_base) ? max_base : base;
    endfunction

    // decision for one input beat; updates the shadow state
    function automatic t_decision predict_decision(logic op, logic route, logic failed,
                                                   logic [RND_W-1:0] rnd);
        t_decision  d;
        logic [63:0] wide_base;
        d = '0;
        d.status = ST_OK;
        if (op == OP_START) begin
            if (route) begin
                seq_open      = 1'b1;
                attempt_count = '0;
                last_base     = '0;
            end else begin
                d.status = ST_ERR;
            end
        end else if (!seq_open) begin
            d.status = ST_ERR;
        end else begin
            if (attempt_count != COUNT_MAX)
                attempt_count = attempt_count + 1'b1;
            d.counted = 1'b1;
            if (failed) begin
                if (attempt_count >= attempt_limit) begin
                    d.exhausted = 1'b1;
                end else begin
                    last_base    = retry_base(int'(attempt_count) - 1);
                    wide_base    = 64'(last_base);
                    d.retry_now  = 1'b1;
                    d.backoff_ms = DLY_W'(wide_base + 64'(rnd) % (wide_base + 64'd1));
                end
            end
        end
        return d;
    endfunction

    always @(posedge i_clk) begin : watch_proc
        t_decision want;
        t_decision got;
        if (!i_rst_n) begin
            init_base     = INIT_BASE_RST;
            max_base      = MAX_BASE_RST;
            attempt_limit = MAX_ATT_RST;
            seq_open      = 1'b0;
            attempt_count = '0;
            last_base     = '0;
            decisions_due.delete();
        end else begin
            // result beat against the oldest decision
            if (i_out.valid && i_out.ready) begin
                got = {i_out.status, i_out.counted, i_out.exhausted,
                       i_out.retry_now, i_out.backoff_ms};
                if (decisions_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result beat with none due: st=%0d cnt=%0d exh=%0d %s",
                                 $realtime, got.status, got.counted, got.exhausted,
                                 $sformatf("rt=%0d dly=%0d", got.retry_now, got.backoff_ms));
                end else begin
                    want = decisions_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: mismatch exp st=%0d cnt=%0d exh=%0d rt=%0d dly=%0d",
                                     $realtime, want.status, want.counted,
                                     want.exhausted, want.retry_now, want.backoff_ms);
                            $display("    got st=%0d cnt=%0d exh=%0d rt=%0d dly=%0d",
                                     got.status, got.counted, got.exhausted,
                                     got.retry_now, got.backoff_ms);
                        end
                    end
                end
            end
            // register write
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_INITIAL_BASE: init_base     = i_cfg.data;
                    CFG_MAX_BASE:     max_base      = i_cfg.data;
                    CFG_MAX_ATTEMPTS: attempt_limit = i_cfg.data[ATT_W-1:0];
                    default: ;
                endcase
            end
            // input beat
            if (i_in.valid && i_in.ready)
                decisions_due.push_back(predict_decision(i_in.operation, i_in.route_mode,
                                                         i_in.attempt_failed,
                                                         i_in.jitter_rnd));
        end
        o_pending    <= decisions_due.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ test/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Stimulus for the retry backoff block: a short directed run over refused
// and accepted starts, notes before a start, exhaustion, zero limit and
// zero or full-scale bases, then random retry sequences under changing
// settings, with bursty input and a stalling result receiver.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbj_pkg::*;

    localparam int COUNT_BITS     = COUNT_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 100;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 55;
    localparam int LONG_SEQ_NOTES = 270;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    rbj_in_if  in_if();
    rbj_out_if out_if();
    rbj_cfg_if cfg_if();

    retry_backoff_with_jitter_top #(.COUNT_BITS(COUNT_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    rbj_backoff_checker #(.COUNT_BITS(COUNT_BITS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_if),
        .i_out        (out_if),
        .i_cfg        (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    int burst_left   = 0;
    int stall_left   = 0;
    int stall_mode   = 0;
    int cycle_count  = 0;
    int idle_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result receiver: stall pattern picked at random from three modes
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count % 256 == 0)
            stall_mode = $urandom_range(0, 2);
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
        end else begin
            out_if.ready <= 1'b1;
            case (stall_mode)
                1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
                2: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(4, 40);
                default: ;
            endcase
        end
    end

    // watchdog on beats of any channel
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted in %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [RND_W-1:0] jitter_word();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [BASE_W-1:0] pick_base();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return BASE_W'(1);
            2:       return BASE_W'($urandom_range(2, 2000));
            3:       return BASE_W'($urandom());
            4:       return '1;
            default: return BASE_W'($urandom_range(1, 64) << $urandom_range(0, 24));
        endcase
    endfunction

    // attempt limit in the low byte, junk above it
    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom());
        case ($urandom_range(0, 4))
            0:       w[ATT_W-1:0] = '0;
            1:       w[ATT_W-1:0] = ATT_W'(1);
            2:       w[ATT_W-1:0] = ATT_W'($urandom_range(2, 8));
            3:       w[ATT_W-1:0] = '1;
            default: ;
        endcase
        return w;
    endfunction

    // one input beat, then possibly a gap that ends the burst
    task automatic send_item(logic op, logic route, logic failed, logic [RND_W-1:0] rnd);
        int gap;
        in_if.valid          <= 1'b1;
        in_if.operation      <= op;
        in_if.route_mode     <= route;
        in_if.attempt_failed <= failed;
        in_if.jitter_rnd     <= rnd;
        do @(posedge i_clk); while (!in_if.ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait until every due result has come back
    task automatic settle_block();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(logic [BASE_W-1:0] init_val, logic [BASE_W-1:0] max_val,
                                  logic [CFG_DATA_W-1:0] limit_word);
        t_cfg_idx              idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx = '{CFG_INITIAL_BASE, CFG_MAX_BASE, CFG_MAX_ATTEMPTS};
        val = '{init_val, max_val, limit_word};
        settle_block();
        cfg_if.valid <= 1'b1;
        for (int k = 0; k < 3; k++) begin
            cfg_if.index <= idx[k];
            cfg_if.data  <= val[k];
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // start in route mode followed by a run of outcome notes
    task automatic run_sequence(int notes);
        send_item(OP_START, 1'b1, 1'($urandom_range(0, 1)), jitter_word());
        for (int n = 0; n < notes; n++)
            send_item(OP_NOTE, 1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0,
                      jitter_word());
    endtask

    initial begin
        int phase_items;
        int notes;

        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.operation      <= OP_START;
        in_if.route_mode     <= 1'b0;
        in_if.attempt_failed <= 1'b0;
        in_if.jitter_rnd     <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= CFG_INITIAL_BASE;
        cfg_if.data          <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: notes before any start, refused starts, doubling, exhaustion
        send_item(OP_NOTE, 1'b1, 1'b1, '1);
        send_item(OP_NOTE, 1'b0, 1'b0, '0);
        send_item(OP_START, 1'b0, 1'b1, '1);
        send_item(OP_START, 1'b1, 1'b0, '0);
        send_item(OP_NOTE, 1'b0, 1'b1, '1);
        send_item(OP_NOTE, 1'b1, 1'b1, '0);
        send_item(OP_START, 1'b0, 1'b0, '1);   // refused, sequence stays open
        send_item(OP_NOTE, 1'b0, 1'b1, 32'h0001_2345);
        send_item(OP_NOTE, 1'b0, 1'b1, '1);    // reaches the limit
        send_item(OP_NOTE, 1'b1, 1'b0, '1);

        // zero maximum clamps a huge first base
        write_settings('1, '0, CFG_DATA_W'(8'hFF));
        send_item(OP_START, 1'b1, 1'b1, '1);
        send_item(OP_NOTE, 1'b0, 1'b1, '1);
        send_item(OP_NOTE, 1'b0, 1'b1, '1);
        send_item(OP_NOTE, 1'b0, 1'b0, '0);

        // limit of zero: every failure exhausted
        write_settings('1, '1, {{(CFG_DATA_W-ATT_W){1'b1}}, {ATT_W{1'b0}}});
        send_item(OP_START, 1'b1, 1'b0, '0);
        send_item(OP_NOTE, 1'b1, 1'b1, '1);
        send_item(OP_NOTE, 1'b1, 1'b0, '1);

        // full-scale base and widest delay
        write_settings('1, '1, CFG_DATA_W'(3));
        send_item(OP_START, 1'b1, 1'b0, '0);
        send_item(OP_NOTE, 1'b0, 1'b1, 32'h7FFF_FFFF);
        send_item(OP_NOTE, 1'b0, 1'b1, '1);
        send_item(OP_NOTE, 1'b0, 1'b1, '1);

        // long sequence: many doublings and a saturating attempt count
        write_settings(BASE_W'(1), '1, CFG_DATA_W'(8'hFF));
        run_sequence(LONG_SEQ_NOTES);

        // random settings and sequences, some noise items
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_settings(pick_base(), pick_base(), pick_limit());
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), jitter_word());
                    phase_items++;
                end else begin
                    notes = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 20)
                                                        : $urandom_range(1, 6);
                    run_sequence(notes);
                    phase_items += notes + 1;
                end
            end
        end

        settle_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
